// ===== rtl/tea_pkg.sv =====
// Shared types, constants and the round mixing function of the TEA block.
package tea_pkg;

  localparam int unsigned WORD_W         = 32;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned ROUNDS_FIELD_W = 6;
  localparam int unsigned RCW            = 7;
  localparam int unsigned ROUND_COUNT_RST = 32;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_WORD0   = 3'd0,
    REG_KEY_WORD1   = 3'd1,
    REG_KEY_WORD2   = 3'd2,
    REG_KEY_WORD3   = 3'd3,
    REG_ROUND_COUNT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [3:0][WORD_W-1:0] key;
    logic [RCW-1:0]         rounds;
    logic [WORD_W-1:0]      dec_sum;
  } cfg_t;

  typedef struct packed {
    logic              dec;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] sum;
  } stage_t;

  function automatic logic [WORD_W-1:0] tea_mix(
    input logic [WORD_W-1:0] v,
    input logic [WORD_W-1:0] s,
    input logic [WORD_W-1:0] ka,
    input logic [WORD_W-1:0] kb
  );
    return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
  endfunction

endpackage

// ===== rtl/tea_if.sv =====
// Valid/ready channel interfaces for TEA input and result transactions.
interface tea_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] block_lo;
  logic [31:0] block_hi;

  modport source (output valid, output cmd, output block_lo, output block_hi, input ready);
  modport sink (input valid, input cmd, input block_lo, input block_hi, output ready);
endinterface

interface tea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_lo;
  logic [31:0] out_hi;

  modport source (output valid, output out_lo, output out_hi, input ready);
  modport sink (input valid, input out_lo, input out_hi, output ready);
endinterface

// ===== rtl/tea_block_cipher_top.sv =====
// TEA block cipher top level: configuration registers and the chain of half-round cells.
//
// Takes one 64-bit block per clock and returns it encrypted (cmd 0) or decrypted (cmd 1)
// with the 128-bit key and round count held in the configuration registers. Each round is
// split over two cells, so a block passes through every cell of the chain, whatever the
// configured round count; rounds beyond the count pass the block through untouched, and a
// count above MAX_ROUNDS acts as MAX_ROUNDS. The whole chain advances together: a stalled
// result in the last cell holds every cell and drops input ready, otherwise one transaction
// is taken every cycle. Write configuration only while no transaction is in flight.
module tea_block_cipher_top #(
  parameter int unsigned MAX_ROUNDS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tea_pkg::WORD_W-1:0]    cfg_wdata_i,
  tea_in_if.sink                        in_i,
  tea_out_if.source                     out_o
);
  import tea_pkg::*;

  localparam int unsigned NCELL = 2 * MAX_ROUNDS;

  cfg_t   cfg;
  logic   adv;
  logic   chain_valid [0:NCELL];
  stage_t chain_data  [0:NCELL];

  tea_cfg_regs #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  assign adv        = !chain_valid[NCELL] || out_o.ready;
  assign in_i.ready = adv;

  assign chain_valid[0]    = in_i.valid;
  assign chain_data[0].dec = in_i.cmd;
  assign chain_data[0].v0  = in_i.block_lo;
  assign chain_data[0].v1  = in_i.block_hi;
  assign chain_data[0].sum = in_i.cmd ? cfg.dec_sum : TEA_DELTA;

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    tea_round_cell #(
      .ROUND_IDX  (c / 2),
      .SECOND_HALF((c % 2) == 1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (chain_valid[c]),
      .data_i  (chain_data[c]),
      .key_i   (cfg.key),
      .rounds_i(cfg.rounds),
      .valid_o (chain_valid[c+1]),
      .data_o  (chain_data[c+1])
    );
  end

  assign out_o.valid  = chain_valid[NCELL];
  assign out_o.out_lo = chain_data[NCELL].v0;
  assign out_o.out_hi = chain_data[NCELL].v1;

endmodule

// ===== rtl/tea_cfg_regs.sv =====
// Configuration registers: key words, saturated round count and decrypt start sum.
module tea_cfg_regs #(
  parameter int unsigned MAX_ROUNDS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tea_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tea_pkg::WORD_W-1:0]          cfg_wdata_i,
  output tea_pkg::cfg_t                       cfg_o
);
  import tea_pkg::*;

  localparam int unsigned PW = WORD_W + RCW;
  localparam logic [RCW-1:0] MAX_C = RCW'(MAX_ROUNDS);
  localparam logic [RCW-1:0] ROUNDS_RST =
    (ROUND_COUNT_RST > MAX_ROUNDS) ? RCW'(MAX_ROUNDS) : RCW'(ROUND_COUNT_RST);
  localparam logic [PW-1:0] DEC_RST_P = PW'(TEA_DELTA) * PW'(ROUNDS_RST);

  logic [3:0][WORD_W-1:0] key_q, key_d;
  logic [RCW-1:0]         rounds_q, rounds_d;
  logic [WORD_W-1:0]      dec_sum_q, dec_sum_d;
  logic [RCW-1:0]         wr_rounds, wr_sat;
  logic [PW-1:0]          wr_prod;

  assign wr_rounds = RCW'(cfg_wdata_i[ROUNDS_FIELD_W-1:0]);
  assign wr_sat    = (wr_rounds > MAX_C) ? MAX_C : wr_rounds;
  assign wr_prod   = PW'(TEA_DELTA) * PW'(wr_sat);

  always_comb begin
    key_d     = key_q;
    rounds_d  = rounds_q;
    dec_sum_d = dec_sum_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_KEY_WORD0: key_d[0] = cfg_wdata_i;
        REG_KEY_WORD1: key_d[1] = cfg_wdata_i;
        REG_KEY_WORD2: key_d[2] = cfg_wdata_i;
        REG_KEY_WORD3: key_d[3] = cfg_wdata_i;
        REG_ROUND_COUNT: begin
          rounds_d  = wr_sat;
          dec_sum_d = wr_prod[WORD_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      rounds_q  <= ROUNDS_RST;
      dec_sum_q <= DEC_RST_P[WORD_W-1:0];
    end else begin
      key_q     <= key_d;
      rounds_q  <= rounds_d;
      dec_sum_q <= dec_sum_d;
    end
  end

  assign cfg_o.key     = key_q;
  assign cfg_o.rounds  = rounds_q;
  assign cfg_o.dec_sum = dec_sum_q;

endmodule

// ===== rtl/tea_round_cell.sv =====
// One half round of TEA: update one block word and hand the transaction on.
module tea_round_cell #(
  parameter int unsigned ROUND_IDX   = 0,
  parameter bit          SECOND_HALF = 1'b0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  tea_pkg::stage_t                    data_i,
  input  logic [3:0][tea_pkg::WORD_W-1:0]    key_i,
  input  logic [tea_pkg::RCW-1:0]            rounds_i,
  output logic                               valid_o,
  output tea_pkg::stage_t                    data_o
);
  import tea_pkg::*;

  localparam logic [RCW-1:0] ROUND_C = RCW'(ROUND_IDX);

  logic              valid_q;
  stage_t            data_q, data_d;
  logic              active;
  logic              src_is_v0;
  logic [WORD_W-1:0] src, tgt, ka, kb, mix, tgt_new;

  assign active    = rounds_i > ROUND_C;
  assign src_is_v0 = data_i.dec ^ SECOND_HALF;
  assign src       = src_is_v0 ? data_i.v0 : data_i.v1;
  assign tgt       = src_is_v0 ? data_i.v1 : data_i.v0;
  assign ka        = src_is_v0 ? key_i[2] : key_i[0];
  assign kb        = src_is_v0 ? key_i[3] : key_i[1];
  assign mix       = tea_mix(src, data_i.sum, ka, kb);
  assign tgt_new   = data_i.dec ? (tgt - mix) : (tgt + mix);

  always_comb begin
    data_d = data_i;
    if (active) begin
      if (src_is_v0) begin
        data_d.v1 = tgt_new;
      end else begin
        data_d.v0 = tgt_new;
      end
      if (SECOND_HALF) begin
        data_d.sum = data_i.dec ? (data_i.sum - TEA_DELTA) : (data_i.sum + TEA_DELTA);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== tb/tb_tea_block_cipher_top.sv =====
// Self-checking testbench of the TEA block cipher top: directed and random blocks, own predictor.
module tb_tea_block_cipher_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tea_pkg::*;

  localparam int unsigned MAX_ROUNDS   = 32;
  localparam int unsigned PIPE_LAT     = 2 * MAX_ROUNDS;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_BLOCKS = 170;
  localparam int unsigned GAP_MAX      = 16;
  localparam logic        CMD_ENCRYPT  = 1'b0;
  localparam logic        CMD_DECRYPT  = 1'b1;

  typedef struct packed {
    logic              dec;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
  } block_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
  } block_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [WORD_W-1:0]    cfg_wdata;

  tea_in_if  in_if ();
  tea_out_if out_if ();

  tea_block_cipher_top #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #5 clk_i = ~clk_i;

  logic [WORD_W-1:0]       key_q [4];
  logic [ROUNDS_FIELD_W-1:0] rounds_q;

  block_req_t   block_queue [$];
  block_res_t   cipher_expect [$];
  block_req_t   cur_blk;
  block_res_t   exp_res;
  bit           drv_busy;
  bit           idle_on;
  int unsigned  drv_gap;
  int unsigned  mon_stall;
  int unsigned  errors = 0;

  function automatic logic [WORD_W-1:0] half_round_mix(
    input logic [WORD_W-1:0] v,
    input logic [WORD_W-1:0] s,
    input logic [WORD_W-1:0] ka,
    input logic [WORD_W-1:0] kb
  );
    logic [WORD_W-1:0] shl;
    logic [WORD_W-1:0] shr;
    shl = v << 4;
    shr = v >> 5;
    return (shl + ka) ^ (v + s) ^ (shr + kb);
  endfunction

  function automatic block_res_t tea_transform(input block_req_t req);
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] s;
    int unsigned       n;
    v0 = req.lo;
    v1 = req.hi;
    n  = (rounds_q > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_q);
    if (req.dec == CMD_ENCRYPT) begin
      s = '0;
      for (int r = 0; r < n; r++) begin
        s  = s + TEA_DELTA;
        v0 = v0 + half_round_mix(v1, s, key_q[0], key_q[1]);
        v1 = v1 + half_round_mix(v0, s, key_q[2], key_q[3]);
      end
    end else begin
      s = TEA_DELTA * WORD_W'(n);
      for (int r = 0; r < n; r++) begin
        v1 = v1 - half_round_mix(v0, s, key_q[2], key_q[3]);
        v0 = v0 - half_round_mix(v1, s, key_q[0], key_q[1]);
        s  = s - TEA_DELTA;
      end
    end
    return '{lo: v0, hi: v1};
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    if (idx <= REG_KEY_WORD3) begin
      key_q[idx[1:0]] = data;
    end else if (idx == REG_ROUND_COUNT) begin
      rounds_q = data[ROUNDS_FIELD_W-1:0];
    end
  endtask

  task automatic push_block(input logic dec, input logic [WORD_W-1:0] lo,
                            input logic [WORD_W-1:0] hi);
    block_queue.push_back('{dec: dec, lo: lo, hi: hi});
  endtask

  // Queue a block and then its inverse, so the second transaction restores the first input.
  task automatic push_round_trip(input logic dec, input logic [WORD_W-1:0] lo,
                                 input logic [WORD_W-1:0] hi);
    block_res_t mid;
    mid = tea_transform('{dec: dec, lo: lo, hi: hi});
    push_block(dec, lo, hi);
    push_block(~dec, mid.lo, mid.hi);
  endtask

  task automatic drain();
    while (block_queue.size() != 0 || drv_busy || cipher_expect.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cur_blk        = '0;
      drv_busy       = 1'b0;
      drv_gap        = 0;
      in_if.valid    <= 1'b0;
      in_if.cmd      <= CMD_ENCRYPT;
      in_if.block_lo <= '0;
      in_if.block_hi <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        cipher_expect.push_back(tea_transform(cur_blk));
        drv_busy = 1'b0;
        drv_gap  = idle_on ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (!drv_busy) begin
        if (drv_gap != 0) begin
          drv_gap--;
        end else if (block_queue.size() != 0) begin
          cur_blk  = block_queue.pop_front();
          drv_busy = 1'b1;
        end
      end
      in_if.valid    <= drv_busy;
      in_if.cmd      <= cur_blk.dec;
      in_if.block_lo <= cur_blk.lo;
      in_if.block_hi <= cur_blk.hi;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mon_stall    = 0;
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (cipher_expect.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transaction lo %h hi %h", $time,
                   out_if.out_lo, out_if.out_hi);
        end else begin
          exp_res = cipher_expect.pop_front();
          if (out_if.out_lo !== exp_res.lo) begin
            errors++;
            $display("%0t: out_lo expected %h actual %h", $time, exp_res.lo, out_if.out_lo);
          end
          if (out_if.out_hi !== exp_res.hi) begin
            errors++;
            $display("%0t: out_hi expected %h actual %h", $time, exp_res.hi, out_if.out_hi);
          end
        end
        mon_stall = idle_on ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (mon_stall != 0) begin
        mon_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [WORD_W-1:0]         keys [4];
    logic [ROUNDS_FIELD_W-1:0] rnd;
    int unsigned               count;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    idle_on        = 1'b1;
    for (int k = 0; k < 4; k++) key_q[k] = '0;
    rounds_q = ROUNDS_FIELD_W'(ROUND_COUNT_RST);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset key and round count, extremes of both words and both commands.
    push_block(CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    push_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000);
    push_block(CMD_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
    push_block(CMD_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
    push_block(CMD_ENCRYPT, 32'h0000_0000, 32'hffff_ffff);
    push_block(CMD_DECRYPT, 32'hffff_ffff, 32'h0000_0000);
    push_block(CMD_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555);
    push_block(CMD_DECRYPT, 32'h5555_5555, 32'haaaa_aaaa);
    push_block(CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
    push_block(CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000);
    push_round_trip(CMD_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
    push_round_trip(CMD_DECRYPT, 32'hdead_beef, 32'hcafe_f00d);
    push_round_trip(CMD_ENCRYPT, 32'hffff_ffff, 32'h0000_0000);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      for (int k = 0; k < 4; k++) keys[k] = $urandom();
      rnd = ROUNDS_FIELD_W'($urandom_range(0, (1 << ROUNDS_FIELD_W) - 1));
      case (p)
        0: begin
          for (int k = 0; k < 4; k++) keys[k] = '0;
          rnd = ROUNDS_FIELD_W'(1);
        end
        1: begin
          for (int k = 0; k < 4; k++) keys[k] = '1;
          rnd = '1;
        end
        2: rnd = '0;
        3: rnd = ROUNDS_FIELD_W'(MAX_ROUNDS);
        4: rnd = ROUNDS_FIELD_W'(MAX_ROUNDS + 1);
        default: ;
      endcase
      idle_on = (p % 3 != 2);
      for (int k = 0; k < 4; k++) begin
        write_reg(CFG_IDX_W'(int'(REG_KEY_WORD0) + k), keys[k]);
      end
      write_reg(REG_ROUND_COUNT, WORD_W'({$urandom() >> ROUNDS_FIELD_W, rnd}));
      for (int i = int'(REG_ROUND_COUNT) + 1; i < (1 << CFG_IDX_W); i++) begin
        write_reg(CFG_IDX_W'(i), $urandom());
      end

      count = 0;
      while (count < PHASE_BLOCKS) begin
        if ($urandom_range(0, 9) < 7) begin
          push_round_trip(logic'($urandom_range(0, 1)), rand_word(), rand_word());
          count += 2;
        end else begin
          push_block(logic'($urandom_range(0, 1)), rand_word(), rand_word());
          count += 1;
        end
      end
      drain();
    end

    repeat (PIPE_LAT + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
